FILE: rtl/core/jcdsl_pkg.sv
// Shared constants, codes and types for the joystick curve and slew limiter.
`timescale 1ns / 1ps
package jcdsl_pkg;

  localparam int CURVE_DEPTH = 128;
  localparam int CURVE_AW    = $clog2(CURVE_DEPTH);
  localparam int TIME_W      = 32;
  localparam int DIV_CNT_W   = $clog2(TIME_W);

  localparam int STICK_W     = 8;
  localparam int CURVE_VAL_W = 7;
  localparam int COEFF_W     = 12;
  localparam int PROD_W      = COEFF_W + CURVE_VAL_W;
  localparam int MUL_CNT_W   = $clog2(CURVE_VAL_W);
  localparam int STEP_W      = 7;
  localparam int POWER_W     = 8;
  localparam int POWER_MAX   = 127;

  localparam logic [STEP_W-1:0] DEF_MS_STEP = STEP_W'(10);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MS_PER_STEP = 3'd4;

  // operation codes
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_CURVE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_SHAPE,
    ST_RCHK,
    ST_DIV,
    ST_LIMIT,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/jcdsl_div.sv
// Bit-serial restoring divider: elapsed time by milliseconds per step.
`timescale 1ns / 1ps
module jcdsl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [jcdsl_pkg::TIME_W-1:0]  dividend,
  input  logic [jcdsl_pkg::STEP_W-1:0]  divisor,
  output logic                          done,
  output logic [jcdsl_pkg::TIME_W-1:0]  quot,
  output logic [jcdsl_pkg::STEP_W-1:0]  rem
);
  import jcdsl_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]    num_r, num_nxt;
  logic [STEP_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]    div_r;
  logic [STEP_W:0]      trial;
  logic                 ge;

  // shift one dividend bit into the partial remainder each cycle
  assign trial = {rem_r, num_r[TIME_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? STEP_W'(trial - {1'b0, div_r}) : trial[STEP_W-1:0];
      num_nxt = {num_r[TIME_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/core/joystick_curve_deadband_slew_limiter_top.sv
// Top level: joystick curve, gain, deadband and slew-rate limiter.
`timescale 1ns / 1ps
// One beat in gives one beat out, one item at a time. A sample runs a curve
// table read, a shift-add gain multiply and shaping, then goes to the output
// register. With ramping on, an elapsed-time check follows shaping. When more
// than one step of time has gone, a bit-serial divide of the elapsed time (one
// quotient bit per cycle) and the limit step follow. Curve writes, ramp
// restarts, inactive samples and the unused code go straight to the output
// register. A result waits in the done state while the previous one is still
// held by out_stall. The curve table is undefined until written.
module joystick_curve_deadband_slew_limiter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic signed [jcdsl_pkg::STICK_W-1:0] in_stick_value,
  input  logic [31:0]                         in_now_ms,
  input  logic [6:0]                          in_curve_index,
  input  logic [jcdsl_pkg::CURVE_VAL_W-1:0]   in_curve_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [jcdsl_pkg::POWER_W-1:0] out_motor_power,
  input  logic                                cfg_wr_en,
  input  logic [jcdsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jcdsl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import jcdsl_pkg::*;

  state_t st_r, st_nxt;

  // configuration
  logic                      active_r;
  logic signed [COEFF_W-1:0] coeff_r;
  logic [6:0]                deadband_r;
  logic                      ramp_en_r;
  logic [STEP_W-1:0]         ms_step_r;

  // ramp state
  logic signed [POWER_W-1:0] last_power_r;
  logic [TIME_W-1:0]         last_upd_r;

  // item datapath
  logic [CURVE_VAL_W-1:0]    curve_mem [CURVE_DEPTH];
  logic [CURVE_AW-1:0]       addr_r;
  logic [CURVE_VAL_W-1:0]    rd_data_r;
  logic                      stick_neg_r;
  logic [TIME_W-1:0]         now_r;
  logic [PROD_W-1:0]         mcand_r;
  logic [CURVE_VAL_W-1:0]    mplier_r;
  logic [PROD_W-1:0]         acc_r;
  logic [MUL_CNT_W-1:0]      mul_cnt_r;
  logic signed [POWER_W-1:0] power_r;
  logic [TIME_W-1:0]         elapsed_r;

  logic                      out_valid_r;
  logic signed [POWER_W-1:0] out_power_r;

  // control strobes
  logic accept, out_free;
  logic do_read, do_load, do_mul, do_shape, do_rchk, do_limit, do_out;

  // combinational helpers
  logic [STICK_W-1:0]        mag;
  logic [CURVE_AW-1:0]       addr_clamp;
  logic [COEFF_W-1:0]        coeff_abs;
  logic [PROD_W-9:0]         m_raw;
  logic [6:0]                m_sat, m_db;
  logic signed [POWER_W-1:0] shaped;
  logic [STEP_W-1:0]         step_eff;
  logic                      short_gap;
  logic                      div_done;
  logic [TIME_W-1:0]         div_quot;
  logic [STEP_W-1:0]         div_rem;
  logic [7:0]                limit;
  logic signed [POWER_W:0]   diff;
  logic [POWER_W:0]          adiff;
  logic                      pass;
  logic signed [POWER_W+1:0] moved;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt = (in_operation == OP_SAMPLE && active_r) ? ST_READ : ST_DONE;
        end
      end
      ST_READ:  st_nxt = ST_LOAD;
      ST_LOAD:  st_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_cnt_r == MUL_CNT_W'(CURVE_VAL_W - 1)) begin
          st_nxt = ST_SHAPE;
        end
      end
      ST_SHAPE: st_nxt = ramp_en_r ? ST_RCHK : ST_DONE;
      ST_RCHK:  st_nxt = short_gap ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_LIMIT;
        end
      end
      ST_LIMIT: st_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    do_read  = 1'b0;
    do_load  = 1'b0;
    do_mul   = 1'b0;
    do_shape = 1'b0;
    do_rchk  = 1'b0;
    do_limit = 1'b0;
    do_out   = 1'b0;
    case (st_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_READ:  do_read  = 1'b1;
      ST_LOAD:  do_load  = 1'b1;
      ST_MUL:   do_mul   = 1'b1;
      ST_SHAPE: do_shape = 1'b1;
      ST_RCHK:  do_rchk  = 1'b1;
      ST_LIMIT: do_limit = 1'b1;
      ST_DONE:  do_out   = out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // sample magnitude clamped to the table
  assign mag = in_stick_value[STICK_W-1] ? STICK_W'(-in_stick_value) : in_stick_value;
  assign addr_clamp = (int'(mag) > CURVE_DEPTH - 1) ? CURVE_AW'(CURVE_DEPTH - 1)
                                                    : CURVE_AW'(mag);

  always_ff @(posedge clk) begin
    if (accept && in_operation == OP_CURVE && int'(in_curve_index) < CURVE_DEPTH) begin
      curve_mem[CURVE_AW'(in_curve_index)] <= in_curve_value;
    end
    if (do_read) begin
      rd_data_r <= curve_mem[addr_r];
    end
  end

  // shaping: truncate the Q4.8 product, saturate, apply deadband, restore sign
  assign coeff_abs = coeff_r[COEFF_W-1] ? COEFF_W'(-coeff_r) : COEFF_W'(coeff_r);
  assign m_raw  = acc_r[PROD_W-1:8];
  assign m_sat  = (int'(m_raw) > POWER_MAX) ? 7'(POWER_MAX) : m_raw[6:0];
  assign m_db   = (m_sat < deadband_r) ? 7'd0 : m_sat;
  assign shaped = (stick_neg_r ^ coeff_r[COEFF_W-1]) ? POWER_W'(-{1'b0, m_db})
                                                     : POWER_W'({1'b0, m_db});

  assign step_eff  = (ms_step_r == '0) ? DEF_MS_STEP : ms_step_r;
  assign short_gap = elapsed_r <= TIME_W'(step_eff);

  jcdsl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (do_rchk && !short_gap),
    .dividend (elapsed_r),
    .divisor  (step_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // slew limit: steps clamped to 255
  assign limit = (|div_quot[TIME_W-1:8]) ? 8'hFF : div_quot[7:0];
  assign diff  = (POWER_W+1)'(last_power_r) - (POWER_W+1)'(power_r);
  assign adiff = diff[POWER_W] ? (POWER_W+1)'(-diff) : (POWER_W+1)'(diff);
  assign pass  = adiff < {1'b0, limit};
  assign moved = (power_r > last_power_r)
               ? (POWER_W+2)'(last_power_r) + (POWER_W+2)'({2'b00, limit})
               : (POWER_W+2)'(last_power_r) - (POWER_W+2)'({2'b00, limit});

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r      <= addr_clamp;
      stick_neg_r <= in_stick_value[STICK_W-1];
      now_r       <= in_now_ms[TIME_W-1:0];
    end
    if (do_load) begin
      mcand_r   <= PROD_W'(coeff_abs);
      mplier_r  <= rd_data_r;
      acc_r     <= '0;
      mul_cnt_r <= '0;
    end
    if (do_mul) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r   <= {mcand_r[PROD_W-2:0], 1'b0};
      mplier_r  <= {1'b0, mplier_r[CURVE_VAL_W-1:1]};
      mul_cnt_r <= mul_cnt_r + 1'b1;
    end
    if (do_shape) begin
      power_r   <= shaped;
      elapsed_r <= now_r - last_upd_r;
    end
    if (do_out) begin
      out_power_r <= last_power_r;
    end
  end

  // configuration and ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      coeff_r      <= COEFF_W'(256);
      deadband_r   <= '0;
      ramp_en_r    <= 1'b0;
      ms_step_r    <= DEF_MS_STEP;
      last_power_r <= '0;
      last_upd_r   <= '0;
    end else begin
      if (accept && in_operation == OP_SAMPLE && !active_r) begin
        last_power_r <= '0;
      end
      if (accept && in_operation == OP_RESTART) begin
        ramp_en_r  <= 1'b1;
        last_upd_r <= in_now_ms[TIME_W-1:0];
        if (ms_step_r == '0) begin
          ms_step_r <= DEF_MS_STEP;
        end
      end
      if (do_shape && !ramp_en_r) begin
        last_power_r <= shaped;
      end
      if (do_rchk && short_gap) begin
        last_power_r <= power_r;
      end
      if (do_limit) begin
        if (pass) begin
          last_power_r <= power_r;
          last_upd_r   <= now_r;
        end else begin
          last_power_r <= moved[POWER_W-1:0];
          last_upd_r   <= now_r - TIME_W'(div_rem);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ACTIVE:      active_r   <= cfg_wdata[0];
          REG_COEFF:       coeff_r    <= cfg_wdata[COEFF_W-1:0];
          REG_DEADBAND:    deadband_r <= cfg_wdata[6:0];
          REG_RAMP_ENABLE: ramp_en_r  <= cfg_wdata[0];
          REG_MS_PER_STEP: ms_step_r  <= cfg_wdata[STEP_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  // output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_power = out_power_r;

endmodule

FILE: test/tb.sv
// Self-checking bench for the joystick curve, deadband and slew limiter top level.
`timescale 1ns / 1ps
module tb;
  import jcdsl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RUN_LIMIT     = 600000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 100;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_operation = OP_SAMPLE;
  logic signed [STICK_W-1:0]  in_stick_value = '0;
  logic [31:0]                in_now_ms = '0;
  logic [6:0]                 in_curve_index = '0;
  logic [CURVE_VAL_W-1:0]     in_curve_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [POWER_W-1:0]  out_motor_power;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  // predictor copy of the block's state and registers
  logic [CURVE_VAL_W-1:0]     curve_copy [CURVE_DEPTH];
  bit                         curve_loaded [CURVE_DEPTH];
  logic signed [POWER_W-1:0]  held_power = '0;
  logic [31:0]                stamp_ms = '0;
  bit                         gain_on = 1'b0;
  logic signed [COEFF_W-1:0]  gain_q48 = 12'sd256;
  logic [6:0]                 band = '0;
  bit                         slew_on = 1'b0;
  logic [STEP_W-1:0]          step_len = DEF_MS_STEP;

  logic signed [POWER_W-1:0]  power_due [$];
  logic signed [POWER_W-1:0]  due_power;
  logic [31:0]                clock_ms = '0;
  bit                         calm = 1'b0;
  int                         hold_left = 0;
  int                         fail_count = 0;
  int                         items_sent = 0;
  int                         results_checked = 0;
  int                         reg_writes = 0;
  int                         cycle_count = 0;

  joystick_curve_deadband_slew_limiter_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_stick_value  (in_stick_value),
    .in_now_ms       (in_now_ms),
    .in_curve_index  (in_curve_index),
    .in_curve_value  (in_curve_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motor_power (out_motor_power),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic int table_slot(input logic signed [STICK_W-1:0] stick);
    int mag;
    mag = (stick < 0) ? -int'(stick) : int'(stick);
    return (mag > CURVE_DEPTH - 1) ? CURVE_DEPTH - 1 : mag;
  endfunction

  // Advance the predictor by one beat and return the power it reports.
  function automatic logic signed [POWER_W-1:0] curve_power_step(
      input logic [1:0] op, input logic signed [STICK_W-1:0] stick,
      input logic [31:0] now, input logic [6:0] idx, input logic [CURVE_VAL_W-1:0] val);
    int c, m, pwr, lim, gap;
    bit neg;
    logic [31:0] step_ms, elapsed, quot;
    case (op)
      OP_SAMPLE: begin
        pwr = 0;
        if (gain_on) begin
          c = (gain_q48 < 0) ? -int'(gain_q48) : int'(gain_q48);
          neg = (stick < 0) != (gain_q48 < 0);
          m = (c * int'(curve_copy[table_slot(stick)])) >> 8;
          if (m > POWER_MAX) m = POWER_MAX;
          if (m < int'(band)) m = 0;
          pwr = neg ? -m : m;
          if (slew_on) begin
            step_ms = (step_len == '0) ? 32'(DEF_MS_STEP) : 32'(step_len);
            elapsed = now - stamp_ms;
            if (elapsed > step_ms) begin
              quot = elapsed / step_ms;
              lim = (quot > 32'd255) ? 255 : int'(quot);
              gap = int'(held_power) - pwr;
              if (gap < 0) gap = -gap;
              if (gap < lim) begin
                stamp_ms = now;
              end else begin
                stamp_ms = now - (elapsed % step_ms);
                pwr = (pwr > int'(held_power)) ? int'(held_power) + lim
                                                : int'(held_power) - lim;
              end
            end
          end
        end
        held_power = POWER_W'(pwr);
      end
      OP_CURVE: begin
        curve_copy[idx] = val;
        curve_loaded[idx] = 1'b1;
      end
      OP_RESTART: begin
        slew_on = 1'b1;
        if (step_len == '0) step_len = DEF_MS_STEP;
        stamp_ms = now;
      end
      default: ;
    endcase
    return held_power;
  endfunction

  function automatic logic signed [STICK_W-1:0] pick_stick();
    logic signed [STICK_W-1:0] s;
    s = STICK_W'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: s = 8'h80;
        1: s = 8'h81;
        2: s = 8'h7f;
        default: s = '0;
      endcase
    end
    // never read a curve entry that has not been written
    while (gain_on && !curve_loaded[table_slot(s)]) s = STICK_W'($urandom);
    return s;
  endfunction

  function automatic logic [31:0] advance_ms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) clock_ms += 32'($urandom_range(0, 30));
    else if (r < 85) clock_ms += 32'($urandom_range(0, 400));
    else if (r < 97) clock_ms += 32'($urandom_range(0, 5000));
    else clock_ms = $urandom;
    return clock_ms;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic signed [STICK_W-1:0] stick,
                           input logic [31:0] now, input logic [6:0] idx,
                           input logic [CURVE_VAL_W-1:0] val);
    int gap;
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_stick_value <= stick;
    in_now_ms      <= now;
    in_curve_index <= idx;
    in_curve_value <= val;
    do @(posedge clk); while (in_stall);
    power_due.push_back(curve_power_step(op, stick, now, idx, val));
    items_sent++;
    // keep valid high when the next beat follows at once
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (power_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_ACTIVE:      gain_on = data[0];
      REG_COEFF:       gain_q48 = data;
      REG_DEADBAND:    band = data[6:0];
      REG_RAMP_ENABLE: slew_on = data[0];
      REG_MS_PER_STEP: step_len = data[STEP_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input int act, input int coeff, input int dead,
                                input int ramp, input int ms);
    write_reg(REG_ACTIVE, act);
    write_reg(REG_COEFF, coeff);
    write_reg(REG_DEADBAND, dead);
    write_reg(REG_RAMP_ENABLE, ramp);
    write_reg(REG_MS_PER_STEP, ms);
  endtask

  task automatic check_reset_state();
    send_item(OP_SAMPLE, 8'sd127, 32'd0, 7'd0, 7'd0);
    send_item(OP_UNUSED, 8'h80, 32'hffff_ffff, 7'd127, 7'd127);
  endtask

  task automatic check_gain_and_shaping();
    send_item(OP_CURVE, 8'sd0, 32'd0, 7'd0, 7'd0);
    send_item(OP_CURVE, 8'sd0, 32'd0, 7'd1, 7'd127);
    send_item(OP_CURVE, 8'sd0, 32'd0, 7'd64, 7'd64);
    send_item(OP_CURVE, 8'sd0, 32'd0, 7'd126, 7'd1);
    send_item(OP_CURVE, 8'sd0, 32'd0, 7'd127, 7'd127);
    write_reg(REG_ACTIVE, 1);
    send_item(OP_SAMPLE, 8'sd127, 32'd0, 7'd0, 7'd0);
    // -128 folds onto the last entry
    send_item(OP_SAMPLE, 8'h80, 32'd0, 7'd0, 7'd0);
    send_item(OP_SAMPLE, -8'sd127, 32'd0, 7'd0, 7'd0);
    send_item(OP_SAMPLE, 8'sd0, 32'd0, 7'd0, 7'd0);
    send_item(OP_SAMPLE, 8'sd1, 32'd0, 7'd0, 7'd0);
    send_item(OP_SAMPLE, -8'sd1, 32'd0, 7'd0, 7'd0);
    write_reg(REG_COEFF, 3);
    send_item(OP_SAMPLE, 8'sd127, 32'd0, 7'd0, 7'd0);
    write_reg(REG_COEFF, -2048);
    send_item(OP_SAMPLE, -8'sd127, 32'd0, 7'd0, 7'd0);
    send_item(OP_SAMPLE, 8'sd64, 32'd0, 7'd0, 7'd0);
    write_reg(REG_COEFF, 2047);
    write_reg(REG_DEADBAND, 127);
    send_item(OP_SAMPLE, 8'sd126, 32'd0, 7'd0, 7'd0);
    send_item(OP_SAMPLE, -8'sd127, 32'd0, 7'd0, 7'd0);
    // a tiny negative gain truncates to zero
    write_reg(REG_COEFF, -1);
    write_reg(REG_DEADBAND, 0);
    send_item(OP_SAMPLE, 8'sd127, 32'd0, 7'd0, 7'd0);
  endtask

  task automatic check_ramp_limits();
    write_reg(REG_COEFF, 256);
    write_reg(REG_RAMP_ENABLE, 1);
    // a zero step length counts as ten
    write_reg(REG_MS_PER_STEP, 0);
    send_item(OP_SAMPLE, 8'sd127, 32'd5, 7'd0, 7'd0);
    send_item(OP_SAMPLE, -8'sd127, 32'd45, 7'd0, 7'd0);
    send_item(OP_RESTART, 8'sd0, 32'hffff_fff0, 7'd0, 7'd0);
    send_item(OP_SAMPLE, -8'sd127, 32'h0000_0010, 7'd0, 7'd0);
    send_item(OP_SAMPLE, -8'sd127, 32'h0010_0000, 7'd0, 7'd0);
    write_reg(REG_MS_PER_STEP, 100);
    send_item(OP_SAMPLE, 8'sd127, 32'h0010_0064, 7'd0, 7'd0);
    send_item(OP_SAMPLE, 8'sd0, 32'h0010_00c9, 7'd0, 7'd0);
    clock_ms = 32'h0010_0200;
  endtask

  task automatic load_curve_table();
    int i;
    for (i = 0; i < CURVE_DEPTH; i++) begin
      send_item(OP_CURVE, STICK_W'($urandom), clock_ms, 7'(i),
                (i == CURVE_DEPTH - 1) ? 7'd127 : 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic run_random_phases();
    int ph, n, r;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(1, 256, 0, 0, 10);
        1: apply_settings(1, -2048, 127, 1, 1);
        2: apply_settings(1, 2047, 0, 1, 100);
        3: apply_settings(0, $urandom_range(0, 4095), $urandom_range(0, 127), 1,
                          $urandom_range(1, 100));
        4: apply_settings(1, $urandom_range(0, 4095), $urandom_range(0, 20), 0, 0);
        default: apply_settings(1, $urandom_range(0, 4095), $urandom_range(0, 30),
                                $urandom_range(0, 1), $urandom_range(1, 100));
      endcase
      calm = (ph == 6);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender once per phase until every result is back
        if (n == PHASE_ITEMS / 2) drain_results();
        r = $urandom_range(0, 99);
        if (r < 72) begin
          send_item(OP_SAMPLE, pick_stick(), advance_ms(), 7'($urandom), 7'($urandom));
        end else if (r < 87) begin
          send_item(OP_CURVE, STICK_W'($urandom), clock_ms, 7'($urandom), 7'($urandom));
        end else if (r < 94) begin
          send_item(OP_RESTART, STICK_W'($urandom), advance_ms(), 7'($urandom),
                    7'($urandom));
        end else begin
          send_item(OP_UNUSED, STICK_W'($urandom), $urandom, 7'($urandom), 7'($urandom));
        end
      end
    end
    calm = 1'b0;
  endtask

  // Check each result beat and draw the stall before the next one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (power_due.size() == 0) begin
          $display("%0t: motor_power expected none, actual %0d", $time, out_motor_power);
          fail_count++;
        end else begin
          due_power = power_due.pop_front();
          if (out_motor_power !== due_power) begin
            $display("%0t: motor_power expected %0d, actual %0d",
                     $time, due_power, out_motor_power);
            fail_count++;
          end
        end
        hold_left = draw_wait();
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run limit reached with %0d results outstanding", $time, power_due.size());
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    check_reset_state();
    check_gain_and_shaping();
    check_ramp_limits();
    load_curve_table();
    run_random_phases();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d beats sent, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("tb: gain, deadband, saturation, ramp clamp and time wrap, then mixed traffic");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: joystick_curve_deadband_slew_limiter_top.f
rtl/core/jcdsl_pkg.sv
rtl/core/jcdsl_div.sv
rtl/core/joystick_curve_deadband_slew_limiter_top.sv
test/tb.sv
